// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assertion helpers shared by the rtl
// each macro expects clk and rst_n in the enclosing scope
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/fba_pkg.sv -----
// ---------------------------------------------------------------------------
// fba_pkg
// opcodes, register indexes, fixed widths and reset values of the frame bin averager
// ---------------------------------------------------------------------------
package fba_pkg;

    localparam int FRAME_LENGTH_BITS = 11;
    localparam int MIN_FRAMES_BITS   = 16;
    localparam int CFG_DATA_BITS     = 16;
    localparam int CFG_INDEX_BITS    = 1;

    localparam logic [FRAME_LENGTH_BITS-1:0] FRAME_LENGTH_RESET = 11'd1024;
    localparam logic [MIN_FRAMES_BITS-1:0]   MIN_FRAMES_RESET   = 16'd1;

    typedef enum logic [0:0] {
        OP_SAMPLE = 1'b0,
        OP_CLEAR  = 1'b1
    } opcode_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_FRAME_LENGTH = 1'b0,
        REG_MIN_FRAMES   = 1'b1
    } cfg_reg_t;

endpackage

// ----- rtl/fba_divider.sv -----
// ---------------------------------------------------------------------------
// fba_divider
// two-lane signed by unsigned restoring divider, one quotient bit per cycle,
// quotient truncated toward zero
// ---------------------------------------------------------------------------
module fba_divider #(
    parameter int SUM_BITS   = 32,
    parameter int COUNT_BITS = 16,
    parameter int QUOT_BITS  = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [SUM_BITS-1:0]  dividend_re,
    input  logic signed [SUM_BITS-1:0]  dividend_im,
    input  logic [COUNT_BITS-1:0]       divisor,
    output logic                        done,
    output logic signed [QUOT_BITS-1:0] quotient_re,
    output logic signed [QUOT_BITS-1:0] quotient_im
);

    localparam int STEP_BITS = $clog2(SUM_BITS);
    localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(SUM_BITS - 1);

    typedef enum logic [0:0] {
        DV_IDLE,
        DV_RUN
    } dv_state_t;

    dv_state_t              state_reg;
    logic [STEP_BITS-1:0]   step_reg;
    logic                   done_reg;
    logic [COUNT_BITS-1:0]  divisor_reg;
    logic                   neg_re_reg;
    logic                   neg_im_reg;
    logic [SUM_BITS-1:0]    quo_re_reg;
    logic [SUM_BITS-1:0]    quo_im_reg;
    logic [COUNT_BITS-1:0]  rem_re_reg;
    logic [COUNT_BITS-1:0]  rem_im_reg;

    logic [COUNT_BITS+SUM_BITS-1:0] step_re;
    logic [COUNT_BITS+SUM_BITS-1:0] step_im;
    logic [SUM_BITS-1:0]            mag_re;
    logic [SUM_BITS-1:0]            mag_im;
    logic [SUM_BITS-1:0]            fix_re;
    logic [SUM_BITS-1:0]            fix_im;

    // shift one dividend bit into the remainder, subtract when it fits
    function automatic logic [COUNT_BITS+SUM_BITS-1:0] div_step(
        input logic [COUNT_BITS-1:0] rem,
        input logic [SUM_BITS-1:0]   quo,
        input logic [COUNT_BITS-1:0] dvs
    );
        logic [COUNT_BITS:0] trial;
        logic                fit;
        trial = {rem, quo[SUM_BITS-1]};
        fit   = (trial >= {1'b0, dvs});
        if (fit)
        begin
            trial = trial - {1'b0, dvs};
        end
        return {trial[COUNT_BITS-1:0], quo[SUM_BITS-2:0], fit};
    endfunction

    always_comb
    begin
        step_re = div_step(rem_re_reg, quo_re_reg, divisor_reg);
        step_im = div_step(rem_im_reg, quo_im_reg, divisor_reg);
        mag_re  = dividend_re[SUM_BITS-1] ? (~dividend_re + 1'b1) : dividend_re;
        mag_im  = dividend_im[SUM_BITS-1] ? (~dividend_im + 1'b1) : dividend_im;
        fix_re  = neg_re_reg ? (~quo_re_reg + 1'b1) : quo_re_reg;
        fix_im  = neg_im_reg ? (~quo_im_reg + 1'b1) : quo_im_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                DV_IDLE:
                begin
                    done_reg <= 1'b0;
                    if (start)
                    begin
                        state_reg <= DV_RUN;
                        step_reg  <= '0;
                    end
                end
                DV_RUN:
                begin
                    step_reg <= step_reg + 1'b1;
                    done_reg <= (step_reg == LAST_STEP);
                    if (step_reg == LAST_STEP)
                    begin
                        state_reg <= DV_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= DV_IDLE;
                    done_reg  <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == DV_IDLE && start)
        begin
            divisor_reg <= divisor;
            neg_re_reg  <= dividend_re[SUM_BITS-1];
            neg_im_reg  <= dividend_im[SUM_BITS-1];
            quo_re_reg  <= mag_re;
            quo_im_reg  <= mag_im;
            rem_re_reg  <= '0;
            rem_im_reg  <= '0;
        end
        else if (state_reg == DV_RUN)
        begin
            rem_re_reg <= step_re[COUNT_BITS+SUM_BITS-1:SUM_BITS];
            quo_re_reg <= step_re[SUM_BITS-1:0];
            rem_im_reg <= step_im[COUNT_BITS+SUM_BITS-1:SUM_BITS];
            quo_im_reg <= step_im[SUM_BITS-1:0];
        end
    end

    assign done        = done_reg;
    assign quotient_re = signed'(fix_re[QUOT_BITS-1:0]);
    assign quotient_im = signed'(fix_im[QUOT_BITS-1:0]);

endmodule

// ----- rtl/frame_bin_averager.sv -----
// ---------------------------------------------------------------------------
// frame_bin_averager
// coherent averaging of complex frames bin by bin, per-bin sums in one
// synchronous memory, averages from a shared two-lane serial divider
// ---------------------------------------------------------------------------
//  channel  handshake               payload
//  in       in_valid / in_stall     opcode, sample_re, sample_im
//  out      out_valid / out_stall   mean_re, mean_im, bin_index,
//                                   frames_counted, last_of_frame, count_saturated
//  cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
//  one item at a time: a clear is taken in the idle state; a sample with no average
//  is accepted, then its bin's sums get a memory read-modify-write; a sample with an
//  average also waits for the bit-serial divider, then for a free output register
//  the next item is taken while a finished average waits in the output register
//  reset clears counters and restores the config defaults; the sum memory is not
//  cleared, the first frame after a clear overwrites each entry
// ---------------------------------------------------------------------------
module frame_bin_averager #(
    parameter int MAX_BINS    = 1024,
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 16,
    localparam int BIN_BITS   = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   opcode,
    input  logic signed [SAMPLE_BITS-1:0]          sample_re,
    input  logic signed [SAMPLE_BITS-1:0]          sample_im,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [SAMPLE_BITS-1:0]          mean_re,
    output logic signed [SAMPLE_BITS-1:0]          mean_im,
    output logic [BIN_BITS-1:0]                    bin_index,
    output logic [COUNT_BITS-1:0]                  frames_counted,
    output logic                                   last_of_frame,
    output logic                                   count_saturated,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [fba_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [fba_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

    localparam int LEN_BITS = $clog2(MAX_BINS + 1);
    localparam int SUM_BITS = SAMPLE_BITS + COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_EMIT
    } state_t;

    state_t                                   state_reg;
    logic [fba_pkg::FRAME_LENGTH_BITS-1:0]    frame_length_reg;
    logic [fba_pkg::MIN_FRAMES_BITS-1:0]      min_frames_reg;
    logic [BIN_BITS-1:0]                      bin_position_reg;
    logic [BIN_BITS-1:0]                      bin_position_next;
    logic [COUNT_BITS-1:0]                    frame_count_reg;
    logic [COUNT_BITS-1:0]                    frame_count_next;
    logic                                     frozen_reg;
    logic                                     frozen_next;

    logic [BIN_BITS-1:0]                      item_bin_reg;
    logic                                     item_last_reg;
    logic                                     item_first_reg;
    logic signed [SAMPLE_BITS-1:0]            item_re_reg;
    logic signed [SAMPLE_BITS-1:0]            item_im_reg;
    logic [2*SUM_BITS-1:0]                    rd_data_reg;

    logic                                     out_valid_reg;
    logic signed [SAMPLE_BITS-1:0]            mean_re_reg;
    logic signed [SAMPLE_BITS-1:0]            mean_im_reg;
    logic [BIN_BITS-1:0]                      bin_index_reg;
    logic [COUNT_BITS-1:0]                    frames_counted_reg;
    logic                                     last_reg;
    logic                                     sat_reg;

    logic [2*SUM_BITS-1:0]                    sum_mem [MAX_BINS];

    logic                                     in_accept;
    logic                                     sample_accept;
    logic                                     clear_accept;
    logic [LEN_BITS-1:0]                      len_eff;
    logic [BIN_BITS-1:0]                      bin_cur;
    logic                                     last_cur;
    logic signed [SUM_BITS-1:0]               rd_re;
    logic signed [SUM_BITS-1:0]               rd_im;
    logic signed [SUM_BITS-1:0]               ext_re;
    logic signed [SUM_BITS-1:0]               ext_im;
    logic signed [SUM_BITS-1:0]               new_re;
    logic signed [SUM_BITS-1:0]               new_im;
    logic                                     mem_wr;
    logic                                     emit_due;
    logic                                     div_start;
    logic                                     div_done;
    logic signed [SAMPLE_BITS-1:0]            div_re;
    logic signed [SAMPLE_BITS-1:0]            div_im;
    logic                                     out_free;

    assign in_stall      = (state_reg != ST_IDLE);
    assign cfg_ready     = (state_reg == ST_IDLE);
    assign in_accept     = in_valid && !in_stall;
    assign sample_accept = in_accept && (fba_pkg::opcode_t'(opcode) == fba_pkg::OP_SAMPLE);
    assign clear_accept  = in_accept && (fba_pkg::opcode_t'(opcode) == fba_pkg::OP_CLEAR);
    assign out_free      = !out_valid_reg || !out_stall;

    // bin and frame bookkeeping for the item being accepted
    always_comb
    begin
        if (frame_length_reg == '0)
        begin
            len_eff = LEN_BITS'(1);
        end
        else if (32'(frame_length_reg) > 32'(MAX_BINS))
        begin
            len_eff = LEN_BITS'(MAX_BINS);
        end
        else
        begin
            len_eff = LEN_BITS'(frame_length_reg);
        end

        // a position left beyond a shortened frame starts a new frame
        if (32'(bin_position_reg) >= 32'(len_eff))
        begin
            bin_cur = '0;
        end
        else
        begin
            bin_cur = bin_position_reg;
        end

        last_cur          = ((32'(bin_cur) + 32'd1) == 32'(len_eff));
        bin_position_next = bin_position_reg;
        frame_count_next  = frame_count_reg;
        frozen_next       = frozen_reg;

        if (clear_accept)
        begin
            bin_position_next = '0;
            frame_count_next  = '0;
            frozen_next       = 1'b0;
        end
        else if (sample_accept)
        begin
            bin_position_next = last_cur ? '0 : BIN_BITS'(bin_cur + 1'b1);
            if (bin_cur == '0)
            begin
                if (frame_count_reg == COUNT_MAX)
                begin
                    frozen_next = 1'b1;
                end
                else
                begin
                    frame_count_next = frame_count_reg + 1'b1;
                    frozen_next      = 1'b0;
                end
            end
        end
    end

    // read-modify-write of the bin's sums
    always_comb
    begin
        rd_re     = signed'(rd_data_reg[2*SUM_BITS-1:SUM_BITS]);
        rd_im     = signed'(rd_data_reg[SUM_BITS-1:0]);
        ext_re    = {{COUNT_BITS{item_re_reg[SAMPLE_BITS-1]}}, item_re_reg};
        ext_im    = {{COUNT_BITS{item_im_reg[SAMPLE_BITS-1]}}, item_im_reg};
        new_re    = item_first_reg ? ext_re : (rd_re + ext_re);
        new_im    = item_first_reg ? ext_im : (rd_im + ext_im);
        mem_wr    = (state_reg == ST_READ) && !frozen_reg;
        emit_due  = (32'(frame_count_reg) >= 32'(min_frames_reg));
        div_start = (state_reg == ST_READ) && emit_due;
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            sum_mem[item_bin_reg] <= {new_re, new_im};
        end
        if (sample_accept)
        begin
            rd_data_reg <= sum_mem[bin_cur];
        end
    end

    fba_divider #(
        .SUM_BITS   (SUM_BITS),
        .COUNT_BITS (COUNT_BITS),
        .QUOT_BITS  (SAMPLE_BITS)
    ) u_divider (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (div_start),
        .dividend_re (frozen_reg ? rd_re : new_re),
        .dividend_im (frozen_reg ? rd_im : new_im),
        .divisor     (frame_count_reg),
        .done        (div_done),
        .quotient_re (div_re),
        .quotient_im (div_im)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            frame_length_reg <= fba_pkg::FRAME_LENGTH_RESET;
            min_frames_reg   <= fba_pkg::MIN_FRAMES_RESET;
            bin_position_reg <= '0;
            frame_count_reg  <= '0;
            frozen_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            bin_position_reg <= bin_position_next;
            frame_count_reg  <= frame_count_next;
            frozen_reg       <= frozen_next;

            if (cfg_valid && cfg_ready)
            begin
                case (fba_pkg::cfg_reg_t'(cfg_index))
                    fba_pkg::REG_FRAME_LENGTH:
                    begin
                        frame_length_reg <= cfg_data[fba_pkg::FRAME_LENGTH_BITS-1:0];
                    end
                    fba_pkg::REG_MIN_FRAMES:
                    begin
                        min_frames_reg <= cfg_data[fba_pkg::MIN_FRAMES_BITS-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end

            // in the emit state the result register is reloaded below instead
            if (out_valid_reg && !out_stall && state_reg != ST_EMIT)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (sample_accept)
                    begin
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    state_reg <= emit_due ? ST_DIV : ST_IDLE;
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (sample_accept)
        begin
            item_bin_reg   <= bin_cur;
            item_last_reg  <= last_cur;
            item_first_reg <= (frame_count_next <= COUNT_BITS'(1));
            item_re_reg    <= sample_re;
            item_im_reg    <= sample_im;
        end
        if (state_reg == ST_EMIT && out_free)
        begin
            mean_re_reg        <= div_re;
            mean_im_reg        <= div_im;
            bin_index_reg      <= item_bin_reg;
            frames_counted_reg <= frame_count_reg;
            last_reg           <= item_last_reg;
            sat_reg            <= frozen_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign mean_re         = mean_re_reg;
    assign mean_im         = mean_im_reg;
    assign bin_index       = bin_index_reg;
    assign frames_counted  = frames_counted_reg;
    assign last_of_frame   = last_reg;
    assign count_saturated = sat_reg;

`include "assert_macros.svh"

    // a sample always leaves a nonzero count, so the divisor is never zero
    `ASSERT_IMPLY(a_count_nonzero_on_read, state_reg == ST_READ, frame_count_reg != '0)
    // the divider only finishes while the sequencer waits for it
    `ASSERT_IMPLY(a_done_in_div, div_done, state_reg == ST_DIV)
    // accumulation stops only with the count pinned at its maximum
    `ASSERT_IMPLY(a_frozen_at_max, frozen_reg, frame_count_reg == COUNT_MAX)
    // a started division keeps the sequencer waiting
    `ASSERT_NEXT(a_div_follows_start, div_start, state_reg == ST_DIV)

endmodule
